// ===== design/dwip_pkg.sv =====
// ----------------------------------------------------------------------------
// dwip_pkg
// Shared types and constants for the dual wheel incremental PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dwip_pkg;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam int DutyW     = 11;
  localparam int AccumW    = 12;
  localparam int IncW      = 14;
  localparam int SumW      = 38;

  localparam logic [CfgIndexW-1:0] REG_GAIN_RATE        = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_GAIN_ANGLE       = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_GAIN_RATE_CHANGE = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_TILT_LIMIT       = 2'd3;

  localparam logic [15:0] GAIN_RATE_RST        = 16'd123;
  localparam logic [15:0] GAIN_ANGLE_RST       = 16'd2458;
  localparam logic [15:0] GAIN_RATE_CHANGE_RST = 16'd819;
  localparam logic [14:0] TILT_LIMIT_RST       = 15'd6400;

  // increment limit of +-20 in units of 2^-19
  localparam logic signed [SumW-1:0] INC_LIMIT = 38'sd10485760;
  localparam logic signed [12:0]     DUTY_MAX  = 13'sd1500;

  typedef struct packed {
    logic signed [15:0] roll_left;
    logic signed [15:0] roll_right;
    logic signed [15:0] rate_left;
    logic signed [15:0] rate_right;
    logic               armed;
  } in_item_t;

  typedef struct packed {
    logic             dir_left;
    logic [DutyW-1:0] duty_left;
    logic             dir_right;
    logic [DutyW-1:0] duty_right;
  } out_item_t;

  typedef struct packed {
    logic [15:0] gain_rate;
    logic [15:0] gain_angle;
    logic [15:0] gain_rate_change;
    logic [14:0] tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic take_in;
    logic armed_in;
    logic adv1;
    logic adv2;
    logic armed2;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [AccumW-1:0] accum;
    logic                     roll_ok;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== design/dwip_lane.sv =====
// ----------------------------------------------------------------------------
// dwip_lane
// One wheel: gain products, clamped Q8 increment and accumulator update.
// ----------------------------------------------------------------------------
`default_nettype none

module dwip_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dwip_pkg::lane_ctl_t ctl,
  input  wire dwip_pkg::cfg_t      cfg,
  input  wire logic signed [15:0]  roll,
  input  wire logic signed [15:0]  rate,
  output dwip_pkg::lane_res_t      res
);

  logic signed [15:0] prev_rate;
  logic signed [32:0] p_rate;
  logic signed [32:0] p_angle;
  logic signed [33:0] p_change;
  logic               ok1;
  logic               ok2;
  logic signed [dwip_pkg::IncW-1:0]   inc_q8;
  logic signed [dwip_pkg::AccumW-1:0] accum;

  logic signed [16:0] change;
  logic signed [16:0] gr_s;
  logic signed [16:0] ga_s;
  logic signed [16:0] gc_s;
  logic signed [16:0] roll_x;
  logic [16:0]        roll_mag;
  logic signed [dwip_pkg::SumW-1:0] sum;
  logic signed [dwip_pkg::SumW-1:0] sum_clamped;
  logic signed [dwip_pkg::SumW-1:0] sum_q8;
  logic signed [20:0] upd;
  logic signed [20:0] upd_div;
  logic signed [dwip_pkg::AccumW-1:0] accum_next;

  always_comb begin
    change   = 17'(rate) - 17'(prev_rate);
    gr_s     = $signed({1'b0, cfg.gain_rate});
    ga_s     = $signed({1'b0, cfg.gain_angle});
    gc_s     = $signed({1'b0, cfg.gain_rate_change});
    roll_x   = 17'(roll);
    roll_mag = roll_x[16] ? unsigned'(-roll_x) : unsigned'(roll_x);
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (ctl.adv1 || ctl.take_in) begin
    end
    if (ctl.take_in) begin
      p_rate   <= gr_s * rate;
      p_angle  <= ga_s * roll;
      p_change <= gc_s * change;
      ok1      <= roll_mag < {2'b00, cfg.tilt_limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rate <= '0;
    end else if (ctl.take_in && ctl.armed_in) begin
      prev_rate <= rate;
    end
  end

  // stage 2: sum, clamp, floor to Q8
  always_comb begin
    sum = (dwip_pkg::SumW'(p_rate) <<< 3) + dwip_pkg::SumW'(p_angle)
        + (dwip_pkg::SumW'(p_change) <<< 3);
    if (sum > dwip_pkg::INC_LIMIT) begin
      sum_clamped = dwip_pkg::INC_LIMIT;
    end else if (sum < -dwip_pkg::INC_LIMIT) begin
      sum_clamped = -dwip_pkg::INC_LIMIT;
    end else begin
      sum_clamped = sum;
    end
    sum_q8 = sum_clamped >>> 11;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      inc_q8 <= sum_q8[dwip_pkg::IncW-1:0];
      ok2    <= ok1;
    end
  end

  // stage 3: accumulator, truncated toward zero and clamped
  always_comb begin
    upd     = (21'(accum) <<< 8) - 21'(inc_q8);
    upd_div = upd[20] ? ((upd + 21'sd255) >>> 8) : (upd >>> 8);
    if (upd_div > 21'(dwip_pkg::DUTY_MAX)) begin
      accum_next = dwip_pkg::AccumW'(dwip_pkg::DUTY_MAX);
    end else if (upd_div < -21'(dwip_pkg::DUTY_MAX)) begin
      accum_next = -dwip_pkg::AccumW'(dwip_pkg::DUTY_MAX);
    end else begin
      accum_next = upd_div[dwip_pkg::AccumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
    end else if (ctl.adv2) begin
      accum <= ctl.armed2 ? accum_next : '0;
    end
  end

  assign res.accum   = accum_next;
  assign res.roll_ok = ok2;

endmodule

`default_nettype wire

// ===== design/dwip_merge.sv =====
// ----------------------------------------------------------------------------
// dwip_merge
// Combines both lanes into one result: tilt cutoff, directions and duties.
// ----------------------------------------------------------------------------
`default_nettype none

module dwip_merge (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire logic                armed,
  input  wire dwip_pkg::lane_res_t res_left,
  input  wire dwip_pkg::lane_res_t res_right,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output dwip_pkg::out_item_t      out_item
);

  logic                       dir_left;
  logic                       dir_right;
  logic [dwip_pkg::DutyW-1:0] duty_left;
  logic [dwip_pkg::DutyW-1:0] duty_right;

  logic                                drive;
  logic signed [dwip_pkg::AccumW-1:0]  mag_left;
  logic signed [dwip_pkg::AccumW-1:0]  mag_right;

  always_comb begin
    drive     = armed && res_left.roll_ok && res_right.roll_ok;
    mag_left  = res_left.accum[dwip_pkg::AccumW-1] ? -res_left.accum : res_left.accum;
    mag_right = res_right.accum[dwip_pkg::AccumW-1] ? -res_right.accum : res_right.accum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dir_left  <= 1'b0;
      dir_right <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && drive) begin
        dir_left  <= res_left.accum > 0;
        dir_right <= !(res_right.accum > 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_left  <= drive ? mag_left[dwip_pkg::DutyW-1:0] : '0;
      duty_right <= drive ? mag_right[dwip_pkg::DutyW-1:0] : '0;
    end
  end

  assign out_item.dir_left   = dir_left;
  assign out_item.duty_left  = duty_left;
  assign out_item.dir_right  = dir_right;
  assign out_item.duty_right = duty_right;

endmodule

`default_nettype wire

// ===== design/dual_wheel_incremental_pid.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid
// Balance controller: two wheel lanes side by side and a merging output stage.
// Registered in order: products, Q8 increment, then accumulator and output.
// Throughput: one request per cycle unless stalled; one-stage accumulator loop.
// Reset: gains and tilt limit to defaults, accumulators, rates, dirs cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_incremental_pid (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire dwip_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output dwip_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_we,
  input  wire logic [dwip_pkg::CfgIndexW-1:0]      cfg_index,
  input  wire logic [dwip_pkg::CfgDataW-1:0]       cfg_data
);

  dwip_pkg::cfg_t      cfg;
  dwip_pkg::lane_ctl_t ctl;
  dwip_pkg::lane_res_t res_left;
  dwip_pkg::lane_res_t res_right;

  logic v1;
  logic v2;
  logic armed1;
  logic armed2;
  logic en1;
  logic en2;
  logic en3;
  logic take_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_rate        <= dwip_pkg::GAIN_RATE_RST;
      cfg.gain_angle       <= dwip_pkg::GAIN_ANGLE_RST;
      cfg.gain_rate_change <= dwip_pkg::GAIN_RATE_CHANGE_RST;
      cfg.tilt_limit       <= dwip_pkg::TILT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dwip_pkg::REG_GAIN_RATE:        cfg.gain_rate        <= cfg_data;
        dwip_pkg::REG_GAIN_ANGLE:       cfg.gain_angle       <= cfg_data;
        dwip_pkg::REG_GAIN_RATE_CHANGE: cfg.gain_rate_change <= cfg_data;
        dwip_pkg::REG_TILT_LIMIT:       cfg.tilt_limit       <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en3      = !out_valid || !out_stall;
    en2      = !v2 || en3;
    en1      = !v1 || en2;
    in_stall = !en1;
    take_in  = in_valid && en1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      armed1 <= in_item.armed;
    end
    if (v1 && en2) begin
      armed2 <= armed1;
    end
  end

  assign ctl.take_in  = take_in;
  assign ctl.armed_in = in_item.armed;
  assign ctl.adv1     = v1 && en2;
  assign ctl.adv2     = v2 && en3;
  assign ctl.armed2   = armed2;

  dwip_lane u_lane_left (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cfg  (cfg),
    .roll (in_item.roll_left),
    .rate (in_item.rate_left),
    .res  (res_left)
  );

  dwip_lane u_lane_right (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cfg  (cfg),
    .roll (in_item.roll_right),
    .rate (in_item.rate_right),
    .res  (res_right)
  );

  dwip_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl.adv2),
    .armed     (armed2),
    .res_left  (res_left),
    .res_right (res_right),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.duty_left <= 11'd1500) && (out_item.duty_right <= 11'd1500))
    else $error("duty above limit");

  a_disarmed_stop: assert property (@(posedge clk) disable iff (rst)
    (ctl.adv2 && !armed2) |=> (out_item.duty_left == '0) && (out_item.duty_right == '0))
    else $error("disarmed request drove a motor");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && out_valid && out_stall) |-> in_stall)
    else $error("request taken into a full pipeline");

endmodule

`default_nettype wire

// ===== tb/tb_dual_wheel_incremental_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_wheel_incremental_pid
// Self-checking bench for the dual wheel balance controller. A directed table
// covers the reset state, gyro and roll extremes, disarm and the tilt cutoff;
// random control ticks under several gain and tilt settings follow. Every
// motor command is compared field by field to a typed row or an in-bench model
// of the two incremental PID loops, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_dual_wheel_incremental_pid;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  dwip_pkg::in_item_t             in_item;
  logic                           out_valid;
  logic                           out_stall;
  dwip_pkg::out_item_t            out_item;
  logic                           cfg_we;
  logic [dwip_pkg::CfgIndexW-1:0] cfg_index;
  logic [dwip_pkg::CfgDataW-1:0]  cfg_data;

  dual_wheel_incremental_pid DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    dwip_pkg::in_item_t  tick;
    bit                  typed;
    dwip_pkg::out_item_t cmd;
  } tick_row_t;

  typedef struct {
    logic [15:0] gr;
    logic [15:0] ga;
    logic [15:0] gd;
    logic [15:0] tl;
    int          n;
    bit          quiet;
  } gain_phase_t;

  // controller model
  dwip_pkg::cfg_t gains;
  int   accum_l, accum_r;
  int   prev_l, prev_r;
  logic dir_l, dir_r;

  dwip_pkg::out_item_t motor_cmd_q[$];
  int  errors, sent, checked, full_duty, stopped;
  bit  idle_on, stall_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dual_wheel_incremental_pid test failed");
    $finish;
  end

  function automatic int next_wheel_accum(int acc, int roll, int rate, int prev);
    longint change, sum, q8, nxt, lim;
    lim    = longint'(dwip_pkg::INC_LIMIT);
    change = longint'(rate) - longint'(prev);
    sum    = longint'(gains.gain_rate) * rate * 8
           + longint'(gains.gain_angle) * roll
           + longint'(gains.gain_rate_change) * change * 8;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    q8  = (sum >= 0) ? sum / 2048 : -((-sum + 2047) / 2048);
    nxt = (longint'(acc) * 256 - q8) / 256;
    if (nxt > longint'(dwip_pkg::DUTY_MAX)) nxt = longint'(dwip_pkg::DUTY_MAX);
    if (nxt < -longint'(dwip_pkg::DUTY_MAX)) nxt = -longint'(dwip_pkg::DUTY_MAX);
    return int'(nxt);
  endfunction

  function automatic dwip_pkg::out_item_t predict_motor_cmd(dwip_pkg::in_item_t it);
    dwip_pkg::out_item_t cmd;
    int rl, rr, tl, tr;
    rl  = $signed(it.roll_left);
    rr  = $signed(it.roll_right);
    tl  = $signed(it.rate_left);
    tr  = $signed(it.rate_right);
    cmd = '0;
    if (it.armed) begin
      accum_l = next_wheel_accum(accum_l, rl, tl, prev_l);
      accum_r = next_wheel_accum(accum_r, rr, tr, prev_r);
      prev_l  = tl;
      prev_r  = tr;
      if ((rl < 0 ? -rl : rl) < int'(gains.tilt_limit) &&
          (rr < 0 ? -rr : rr) < int'(gains.tilt_limit)) begin
        dir_l          = accum_l > 0;
        dir_r          = !(accum_r > 0);
        cmd.duty_left  = dwip_pkg::DutyW'(accum_l < 0 ? -accum_l : accum_l);
        cmd.duty_right = dwip_pkg::DutyW'(accum_r < 0 ? -accum_r : accum_r);
      end
    end else begin
      accum_l = 0;
      accum_r = 0;
    end
    cmd.dir_left  = dir_l;
    cmd.dir_right = dir_r;
    return cmd;
  endfunction

  function automatic dwip_pkg::in_item_t mk_tick(int rl, int rr, int tl, int tr, bit armed);
    dwip_pkg::in_item_t it;
    it.roll_left  = 16'(rl);
    it.roll_right = 16'(rr);
    it.rate_left  = 16'(tl);
    it.rate_right = 16'(tr);
    it.armed      = armed;
    return it;
  endfunction

  function automatic dwip_pkg::out_item_t mk_cmd(bit dl, int ul, bit dr, int ur);
    dwip_pkg::out_item_t c;
    c.dir_left   = dl;
    c.duty_left  = dwip_pkg::DutyW'(ul);
    c.dir_right  = dr;
    c.duty_right = dwip_pkg::DutyW'(ur);
    return c;
  endfunction

  function automatic logic [15:0] pick_roll(bit tidy, int lean);
    int k;
    k = $urandom_range(9);
    if (tidy && k < 8) return 16'(lean + int'($urandom_range(400)) - 200);
    if (k[0]) begin
      k = int'(gains.tilt_limit) + int'($urandom_range(2)) - 1;
      return 16'($urandom_range(1) ? k : -k);
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_rate();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 16'(int'($urandom_range(600)) - 300);
    if (k < 8) return 16'($urandom);
    return (k == 8) ? 16'h7FFF : 16'h8000;
  endfunction

  function automatic dwip_pkg::in_item_t random_tick(bit tidy, int lean_l, int lean_r);
    dwip_pkg::in_item_t it;
    it.armed      = $urandom_range(99) < (tidy ? 98 : 60);
    it.roll_left  = pick_roll(tidy, lean_l);
    it.roll_right = pick_roll(tidy, lean_r);
    it.rate_left  = pick_rate();
    it.rate_right = pick_rate();
    return it;
  endfunction

  task automatic send_tick(dwip_pkg::in_item_t it, bit typed,
                           dwip_pkg::out_item_t typed_cmd);
    dwip_pkg::out_item_t cmd;
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    cmd = predict_motor_cmd(it);
    motor_cmd_q.push_back(typed ? typed_cmd : cmd);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (motor_cmd_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(logic [dwip_pkg::CfgIndexW-1:0] idx,
                           logic [dwip_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_gains(gain_phase_t ph);
    cfg_write(dwip_pkg::REG_GAIN_RATE, ph.gr);
    cfg_write(dwip_pkg::REG_GAIN_ANGLE, ph.ga);
    cfg_write(dwip_pkg::REG_GAIN_RATE_CHANGE, ph.gd);
    cfg_write(dwip_pkg::REG_TILT_LIMIT, ph.tl);
    cfg_we <= 1'b0;
    gains.gain_rate        = ph.gr;
    gains.gain_angle       = ph.ga;
    gains.gain_rate_change = ph.gd;
    gains.tilt_limit       = ph.tl[14:0];
  endtask

  // response side: random stall and in-order compare
  always @(posedge clk) begin
    dwip_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= stall_on && ($urandom_range(99) < 9);
      if (out_valid && !out_stall) begin
        if (motor_cmd_q.size() == 0) begin
          $error("motor command with no request outstanding");
          errors++;
        end else begin
          want = motor_cmd_q.pop_front();
          checked++;
          if (out_item.duty_left == 1500 || out_item.duty_right == 1500) full_duty++;
          if (out_item.duty_left == 0 && out_item.duty_right == 0) stopped++;
          if (out_item.dir_left !== want.dir_left) begin
            $error("dir_left: expected %0d, got %0d", want.dir_left, out_item.dir_left);
            errors++;
          end
          if (out_item.duty_left !== want.duty_left) begin
            $error("duty_left: expected %0d, got %0d", want.duty_left, out_item.duty_left);
            errors++;
          end
          if (out_item.dir_right !== want.dir_right) begin
            $error("dir_right: expected %0d, got %0d", want.dir_right, out_item.dir_right);
            errors++;
          end
          if (out_item.duty_right !== want.duty_right) begin
            $error("duty_right: expected %0d, got %0d", want.duty_right,
                   out_item.duty_right);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    tick_row_t   directed_ticks[17];
    gain_phase_t plan[6];
    int left, burst_len, span, lean_l, lean_r;
    bit tidy;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = dwip_pkg::REG_GAIN_RATE;
    cfg_data  = '0;
    idle_on   = 1'b1;
    stall_on  = 1'b1;
    errors    = 0;
    sent      = 0;
    checked   = 0;
    full_duty = 0;
    stopped   = 0;
    gains     = '{dwip_pkg::GAIN_RATE_RST, dwip_pkg::GAIN_ANGLE_RST,
                  dwip_pkg::GAIN_RATE_CHANGE_RST, dwip_pkg::TILT_LIMIT_RST};
    accum_l   = 0;
    accum_r   = 0;
    prev_l    = 0;
    prev_r    = 0;
    dir_l     = 1'b0;
    dir_r     = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset gains; saturating gyro swings, disarm, tilt cutoff at both ends
    directed_ticks = '{
      '{mk_tick(0, 0, 0, 0, 1),                   1, mk_cmd(0, 0, 1, 0)},
      '{mk_tick(0, 0, 32767, 32767, 1),           1, mk_cmd(0, 20, 1, 20)},
      '{mk_tick(0, 0, -32768, -32768, 1),         1, mk_cmd(0, 0, 1, 0)},
      '{mk_tick(0, 0, -32768, -32768, 1),         1, mk_cmd(1, 20, 0, 20)},
      '{mk_tick(0, 0, 32767, 32767, 0),           1, mk_cmd(1, 0, 0, 0)},
      '{mk_tick(32767, 0, 0, 0, 1),               1, mk_cmd(1, 0, 0, 0)},
      '{mk_tick(-32768, 0, 0, 0, 1),              1, mk_cmd(1, 0, 0, 0)},
      '{mk_tick(6400, 0, 0, 0, 1),                0, '0},
      '{mk_tick(6399, -6399, 0, 0, 1),            0, '0},
      '{mk_tick(0, -6400, 0, 0, 1),               0, '0},
      '{mk_tick(-1, 1, -1, 1, 1),                 0, '0},
      '{mk_tick(1, -1, 1, -1, 1),                 0, '0},
      '{mk_tick(0, 0, 0, 0, 0),                   0, '0},
      '{mk_tick(0, 0, 0, 0, 1),                   0, '0},
      '{mk_tick(-21846, 21845, 21845, -21846, 1), 0, '0},
      '{mk_tick(300, -300, 40, -40, 1),           0, '0},
      '{mk_tick(300, -300, 40, -40, 1),           0, '0}
    };
    foreach (directed_ticks[i])
      send_tick(directed_ticks[i].tick, directed_ticks[i].typed, directed_ticks[i].cmd);
    wait_idle();

    plan = '{
      '{dwip_pkg::GAIN_RATE_RST, dwip_pkg::GAIN_ANGLE_RST, dwip_pkg::GAIN_RATE_CHANGE_RST,
        16'(dwip_pkg::TILT_LIMIT_RST), 300, 0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 100, 0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 250, 1},
      '{16'd0, 16'd0, 16'd0, 16'd0, 300, 0},
      '{16'd1, 16'd1, 16'd1, 16'h7FFF, 200, 0},
      '{16'd4096, 16'd8000, 16'd2000, 16'd2000, 300, 0}
    };
    plan[3].gr = 16'($urandom_range(8191));
    plan[3].ga = 16'($urandom_range(16383));
    plan[3].gd = 16'($urandom_range(8191));
    plan[3].tl = 16'($urandom_range(100, 12000));

    foreach (plan[p]) begin
      program_gains(plan[p]);
      idle_on  = !plan[p].quiet;
      stall_on = !plan[p].quiet;
      span     = int'(gains.tilt_limit) * 3 / 4;
      if (span > 4000) span = 4000;
      left = plan[p].n;
      while (left > 0) begin
        burst_len = $urandom_range(20, 90);
        tidy      = $urandom_range(99) < 75;
        lean_l    = int'($urandom_range(2 * span)) - span;
        lean_r    = int'($urandom_range(2 * span)) - span;
        repeat (burst_len) begin
          if (left > 0) begin
            send_tick(random_tick(tidy, lean_l, lean_r), 0, '0);
            left--;
          end
        end
      end
      wait_idle();
    end

    idle_on  = 1'b1;
    stall_on = 1'b1;
    repeat (10) @(posedge clk);

    $display("%0d control ticks over %0d gain/tilt settings, %0d motor commands compared",
             sent, $size(plan), checked);
    $display("%0d commands hit full duty, %0d had both wheels stopped", full_duty, stopped);
    if (errors == 0) begin
      $display("dual_wheel_incremental_pid test passed");
    end else begin
      $display("dual_wheel_incremental_pid test failed");
    end
    $finish;
  end

endmodule
